FILE: sv/wpbt_pkg.sv
`default_nettype none
package wpbt_pkg;

    // configuration register
    localparam int CFG_BITS    = 10;
    localparam int LIMIT_FLOOR = 4;
    localparam logic [CFG_BITS-1:0] LIMIT_RESET = 10'd100;

    // result count field
    localparam int HELD_BITS = 11;

    // a quarter of the limit is dropped on overflow
    localparam int DROP_SHIFT = 2;

    // words buffered between front and back
    localparam int QDEPTH = 2;

    typedef enum logic {
        OP_ADD   = 1'b0,
        OP_CLEAR = 1'b1
    } op_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_SCAN = 1'b1
    } state_t;

    // head of the command queue as seen by the back end
    typedef struct packed {
        logic valid;
        op_t  op;
    } q_ctrl_t;

endpackage
`default_nettype wire

FILE: sv/wpbt_ram.sv
`default_nettype none
module wpbt_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule
`default_nettype wire

FILE: sv/wpbt_front.sv
`default_nettype none
module wpbt_front
    import wpbt_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
    output q_ctrl_t                            q_ctrl,
    input  wire logic                          q_pop,
    output logic signed [SAMPLE_BITS-1:0]      q_x,
    output logic signed [SAMPLE_BITS-1:0]      q_y
);

    localparam int PW = $clog2(QDEPTH);
    localparam int NW = $clog2(QDEPTH + 1);

    op_t                          op_q   [QDEPTH];
    logic signed [SAMPLE_BITS-1:0] x_q   [QDEPTH];
    logic signed [SAMPLE_BITS-1:0] y_q   [QDEPTH];
    logic [PW-1:0]                wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]                rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]                fill_reg, fill_next;
    logic                         push;
    op_t                          op_in;

    // classify the incoming word
    assign op_in    = cmd ? OP_CLEAR : OP_ADD;
    assign in_ready = (fill_reg != NW'(QDEPTH));
    assign push     = in_valid && in_ready;

    // queue pointers and fill level
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        fill_next   = fill_reg;
        if (push)
        begin
            wr_ptr_next = wr_ptr_reg + PW'(1);
        end
        if (q_pop)
        begin
            rd_ptr_next = rd_ptr_reg + PW'(1);
        end
        if (push && !q_pop)
        begin
            fill_next = fill_reg + NW'(1);
        end
        else if (!push && q_pop)
        begin
            fill_next = fill_reg - NW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

    // queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            op_q[wr_ptr_reg] <= op_in;
            x_q[wr_ptr_reg]  <= sample_x;
            y_q[wr_ptr_reg]  <= sample_y;
        end
    end

    // head of queue
    assign q_ctrl.valid = (fill_reg != '0);
    assign q_ctrl.op    = op_q[rd_ptr_reg];
    assign q_x          = x_q[rd_ptr_reg];
    assign q_y          = y_q[rd_ptr_reg];

endmodule
`default_nettype wire

FILE: sv/wpbt_back.sv
`default_nettype none
module wpbt_back
    import wpbt_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic [CFG_BITS-1:0]           max_points,
    input  wire q_ctrl_t                       q_ctrl,
    output logic                               q_pop,
    input  wire logic signed [SAMPLE_BITS-1:0] q_x,
    input  wire logic signed [SAMPLE_BITS-1:0] q_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      bound_min_x,
    output logic signed [SAMPLE_BITS-1:0]      bound_max_x,
    output logic signed [SAMPLE_BITS-1:0]      bound_min_y,
    output logic signed [SAMPLE_BITS-1:0]      bound_max_y,
    output logic [HELD_BITS-1:0]               points_held
);

    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int LW = (CW > CFG_BITS) ? CW : CFG_BITS;
    localparam int SB = SAMPLE_BITS;

    state_t                state_reg, state_next;
    logic [CW-1:0]         held_reg, held_next;
    logic [AW-1:0]         oldest_reg, oldest_next;
    logic signed [SB-1:0]  lo_x_reg, lo_x_next, hi_x_reg, hi_x_next;
    logic signed [SB-1:0]  lo_y_reg, lo_y_next, hi_y_reg, hi_y_next;
    logic [AW-1:0]         scan_addr_reg, scan_addr_next;
    logic [CW-1:0]         scan_left_reg, scan_left_next;
    logic                  rd_valid_reg, rd_valid_next;
    logic                  out_valid_reg, out_valid_next;

    logic [LW-1:0]         mp_w, lim_w;
    logic [CW-1:0]         lim, drop, cnt_inc;
    logic [AW-1:0]         slot, oldest_drop;
    logic                  take, overflow;

    logic                  ram_wr_en, ram_rd_en;
    logic [AW-1:0]         ram_rd_addr;
    logic [2*SB-1:0]       ram_rd_data;
    logic signed [SB-1:0]  rd_x, rd_y;
    logic [CW+HELD_BITS-1:0] held_w;

    // circular address add, both operands below the capacity
    function automatic logic [AW-1:0] wrap_add(logic [AW-1:0] a, logic [CW-1:0] b);
        logic [AW:0] sum;
        sum = (AW+1)'(a) + (AW+1)'(b);
        if (sum >= (AW+1)'(CAPACITY))
        begin
            sum = sum - (AW+1)'(CAPACITY);
        end
        return sum[AW-1:0];
    endfunction

    // limit in use, saturated to the legal range
    always_comb
    begin
        mp_w = LW'(max_points);
        if (mp_w < LW'(LIMIT_FLOOR))
        begin
            lim_w = LW'(LIMIT_FLOOR);
        end
        else if (mp_w > LW'(CAPACITY - 1))
        begin
            lim_w = LW'(CAPACITY - 1);
        end
        else
        begin
            lim_w = mp_w;
        end
    end

    assign lim         = lim_w[CW-1:0];
    assign drop        = lim >> DROP_SHIFT;
    assign cnt_inc     = held_reg + CW'(1);
    assign overflow    = (cnt_inc > lim);
    assign slot        = wrap_add(oldest_reg, held_reg);
    assign oldest_drop = wrap_add(oldest_reg, drop);
    assign take        = (state_reg == ST_IDLE) && q_ctrl.valid &&
                         (!out_valid_reg || out_ready);
    assign q_pop       = take;

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && q_ctrl.op == OP_ADD && overflow)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_left_reg == '0 && !rd_valid_reg)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        held_next      = held_reg;
        oldest_next    = oldest_reg;
        lo_x_next      = lo_x_reg;
        hi_x_next      = hi_x_reg;
        lo_y_next      = lo_y_reg;
        hi_y_next      = hi_y_reg;
        scan_addr_next = scan_addr_reg;
        scan_left_next = scan_left_reg;
        rd_valid_next  = 1'b0;
        out_valid_next = out_valid_reg && !out_ready;
        ram_wr_en      = 1'b0;
        ram_rd_en      = 1'b0;
        ram_rd_addr    = scan_addr_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take && q_ctrl.op == OP_CLEAR)
                begin
                    held_next      = '0;
                    oldest_next    = '0;
                    out_valid_next = 1'b1;
                end
                else if (take)
                begin
                    ram_wr_en = 1'b1;
                    if (overflow)
                    begin
                        // drop the oldest quarter and rescan what is left
                        oldest_next    = oldest_drop;
                        held_next      = cnt_inc - drop;
                        lo_x_next      = q_x;
                        hi_x_next      = q_x;
                        lo_y_next      = q_y;
                        hi_y_next      = q_y;
                        scan_addr_next = oldest_drop;
                        scan_left_next = cnt_inc - drop;
                    end
                    else
                    begin
                        held_next      = cnt_inc;
                        out_valid_next = 1'b1;
                        if (held_reg == '0)
                        begin
                            lo_x_next = q_x;
                            hi_x_next = q_x;
                            lo_y_next = q_y;
                            hi_y_next = q_y;
                        end
                        else
                        begin
                            if (q_x <= lo_x_reg) lo_x_next = q_x;
                            if (q_x >= hi_x_reg) hi_x_next = q_x;
                            if (q_y <= lo_y_reg) lo_y_next = q_y;
                            if (q_y >= hi_y_reg) hi_y_next = q_y;
                        end
                    end
                end
            end
            ST_SCAN:
            begin
                // issue one read a cycle
                if (scan_left_reg != '0)
                begin
                    ram_rd_en      = 1'b1;
                    scan_addr_next = wrap_add(scan_addr_reg, CW'(1));
                    scan_left_next = scan_left_reg - CW'(1);
                    rd_valid_next  = 1'b1;
                end
                // fold the word read last cycle
                if (rd_valid_reg)
                begin
                    if (rd_x < lo_x_reg) lo_x_next = rd_x;
                    if (rd_x > hi_x_reg) hi_x_next = rd_x;
                    if (rd_y < lo_y_reg) lo_y_next = rd_y;
                    if (rd_y > hi_y_reg) hi_y_next = rd_y;
                end
                if (scan_left_reg == '0 && !rd_valid_reg)
                begin
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            held_reg      <= '0;
            oldest_reg    <= '0;
            lo_x_reg      <= '0;
            hi_x_reg      <= '0;
            lo_y_reg      <= '0;
            hi_y_reg      <= '0;
            scan_addr_reg <= '0;
            scan_left_reg <= '0;
            rd_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            held_reg      <= held_next;
            oldest_reg    <= oldest_next;
            lo_x_reg      <= lo_x_next;
            hi_x_reg      <= hi_x_next;
            lo_y_reg      <= lo_y_next;
            hi_y_reg      <= hi_y_next;
            scan_addr_reg <= scan_addr_next;
            scan_left_reg <= scan_left_next;
            rd_valid_reg  <= rd_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // point history, x in the upper half
    wpbt_ram #(
        .WIDTH (2 * SB),
        .DEPTH (CAPACITY)
    ) u_store (
        .clk     (clk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot),
        .wr_data ({q_x, q_y}),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    assign rd_x = ram_rd_data[2*SB-1:SB];
    assign rd_y = ram_rd_data[SB-1:0];

    // result word straight from the state, which holds while it waits
    assign held_w      = (CW+HELD_BITS)'(held_reg);
    assign out_valid   = out_valid_reg;
    assign bound_min_x = lo_x_reg;
    assign bound_max_x = hi_x_reg;
    assign bound_min_y = lo_y_reg;
    assign bound_max_y = hi_y_reg;
    assign points_held = held_w[HELD_BITS-1:0];

endmodule
`default_nettype wire

FILE: sv/windowed_point_bounds_tracker.sv
// windowed point bounds tracker
//
// input channel (in_valid/in_ready): one word per point or command. cmd 0
// adds the point (sample_x, sample_y, signed Q16.16), cmd 1 empties the
// history. output channel (out_valid/out_ready): one word per input word
// with the bounding box of the held points and the count held.
// cfg_wr_en/cfg_wr_data write max_points; write it only while idle.
//
// a two-word queue sits between the accepting front end and the executing
// back end. the back end registers the result of a plain add or a clear
// when it takes the word, and such words stream at one per cycle while
// out_ready is high. when the count passes the limit the oldest limit/4
// points are dropped and the remaining n points are reread from the
// history memory, one read a cycle through its single read port, n being
// about three quarters of the limit; no word is taken until it is done.
//
// reset empties the history, zeroes the bounds and sets max_points to 100.
// while out_ready is low the result word holds and the queue keeps
// taking input until it is full.
`default_nettype none
module windowed_point_bounds_tracker
    import wpbt_pkg::*;
#(
    parameter int CAPACITY    = 1024,
    parameter int SAMPLE_BITS = 32
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          cfg_wr_en,
    input  wire logic [CFG_BITS-1:0]           cfg_wr_data,
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic                          cmd,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_x,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_y,
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic signed [SAMPLE_BITS-1:0]      bound_min_x,
    output logic signed [SAMPLE_BITS-1:0]      bound_max_x,
    output logic signed [SAMPLE_BITS-1:0]      bound_min_y,
    output logic signed [SAMPLE_BITS-1:0]      bound_max_y,
    output logic [HELD_BITS-1:0]               points_held
);

    logic [CFG_BITS-1:0]           max_points_reg;
    q_ctrl_t                       q_ctrl;
    logic                          q_pop;
    logic signed [SAMPLE_BITS-1:0] q_x, q_y;

    // limit register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_points_reg <= LIMIT_RESET;
        end
        else if (cfg_wr_en)
        begin
            max_points_reg <= cfg_wr_data;
        end
    end

    wpbt_front #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .cmd      (cmd),
        .sample_x (sample_x),
        .sample_y (sample_y),
        .q_ctrl   (q_ctrl),
        .q_pop    (q_pop),
        .q_x      (q_x),
        .q_y      (q_y)
    );

    wpbt_back #(
        .CAPACITY    (CAPACITY),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .max_points  (max_points_reg),
        .q_ctrl      (q_ctrl),
        .q_pop       (q_pop),
        .q_x         (q_x),
        .q_y         (q_y),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .bound_min_x (bound_min_x),
        .bound_max_x (bound_max_x),
        .bound_min_y (bound_min_y),
        .bound_max_y (bound_max_y),
        .points_held (points_held)
    );

endmodule
`default_nettype wire

FILE: sv/wpbt_checker.sv
`default_nettype none
module wpbt_checker
    import wpbt_pkg::*;
#(
    parameter int SAMPLE_BITS = 32
) (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          cfg_wr_en,
    input wire logic [CFG_BITS-1:0]           cfg_wr_data,
    input wire logic                          in_valid,
    input wire logic                          in_ready,
    input wire logic                          cmd,
    input wire logic signed [SAMPLE_BITS-1:0] sample_x,
    input wire logic signed [SAMPLE_BITS-1:0] sample_y,
    input wire logic                          out_valid,
    input wire logic                          out_ready,
    input wire logic signed [SAMPLE_BITS-1:0] bound_min_x,
    input wire logic signed [SAMPLE_BITS-1:0] bound_max_x,
    input wire logic signed [SAMPLE_BITS-1:0] bound_min_y,
    input wire logic signed [SAMPLE_BITS-1:0] bound_max_y,
    input wire logic [HELD_BITS-1:0]          points_held
);

    // no result word is offered while in reset
    a_reset_quiet: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("result offered during reset");

    // a stalled result word holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(bound_min_x) &&
        $stable(bound_max_x) && $stable(bound_min_y) &&
        $stable(bound_max_y) && $stable(points_held))
        else $error("stalled result changed");

    // the box is never inverted, also when stale
    a_box_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> bound_min_x <= bound_max_x && bound_min_y <= bound_max_y)
        else $error("bounding box inverted");

    // a single held point is a degenerate box
    a_single_point: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && points_held == HELD_BITS'(1) |->
        bound_min_x == bound_max_x && bound_min_y == bound_max_y)
        else $error("single point gives a wide box");

endmodule

bind windowed_point_bounds_tracker wpbt_checker #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_wpbt_checker (.*);
`default_nettype wire
